FILE: hw/rtl/atrp_pkg.sv
// Shared constants for the AT response parser: status codes and character codes.
package atrp_pkg;

    // Status reported for each received word
    localparam logic [1:0] STATUS_NOT_READY = 2'd0;
    localparam logic [1:0] STATUS_OK        = 2'd1;
    localparam logic [1:0] STATUS_ERROR     = 2'd2;

    // Characters of the response grammar
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Text range accepted in response lines, both ends inclusive
    localparam logic [7:0] TEXT_LO  = 8'd32;
    localparam logic [7:0] TEXT_HI  = 8'd128;

endpackage

FILE: hw/rtl/atrp_parser.sv
// Grammar state machine of the AT response parser: parse state and per-word status.
module atrp_parser
    import atrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    output logic [1:0] o_status
);

    typedef enum logic [4:0] {
        S_WAIT_CR    = 5'd0,
        S_WAIT_LF    = 5'd1,
        S_FIRST      = 5'd2,
        S_OK_K       = 5'd3,
        S_OK_CR      = 5'd4,
        S_OK_LF      = 5'd5,
        S_ERR_R1     = 5'd7,
        S_ERR_R2     = 5'd8,
        S_ERR_O      = 5'd9,
        S_ERR_R3     = 5'd10,
        S_ERR_CR     = 5'd11,
        S_ERR_LF     = 5'd12,
        S_TEXT       = 5'd14,
        S_TEXT_LF    = 5'd15,
        S_LINE_START = 5'd16,
        S_BLANK_LF   = 5'd17,
        S_FINAL      = 5'd18
    } t_parse_state;

    t_parse_state r_state;
    t_parse_state n_state;
    logic [1:0]   n_status;

    // Single byte match: advance on hit, flag error and hold on miss; a miss while waiting for CR holds without error
    always_comb begin
        n_state  = r_state;
        n_status = STATUS_NOT_READY;
        case (r_state)
            S_WAIT_CR: begin
                if (i_char == CH_CR) n_state = S_WAIT_LF;
            end
            S_WAIT_LF: begin
                if (i_char == CH_LF) n_state = S_FIRST;
                else n_status = STATUS_ERROR;
            end
            S_FIRST: begin
                if (i_char == CH_O) n_state = S_OK_K;
                else if (i_char == CH_PLUS) n_state = S_TEXT;
                else if (i_char == CH_E) n_state = S_ERR_R1;
                else n_status = STATUS_ERROR;
            end
            S_OK_K: begin
                if (i_char == CH_K) n_state = S_OK_CR;
                else n_status = STATUS_ERROR;
            end
            S_OK_CR: begin
                if (i_char == CH_CR) n_state = S_OK_LF;
                else n_status = STATUS_ERROR;
            end
            S_OK_LF: begin
                if (i_char == CH_LF) begin
                    n_state  = S_WAIT_CR;
                    n_status = STATUS_OK;
                end else begin
                    n_status = STATUS_ERROR;
                end
            end
            S_ERR_R1: begin
                if (i_char == CH_R) n_state = S_ERR_R2;
                else n_status = STATUS_ERROR;
            end
            S_ERR_R2: begin
                if (i_char == CH_R) n_state = S_ERR_O;
                else n_status = STATUS_ERROR;
            end
            S_ERR_O: begin
                if (i_char == CH_O) n_state = S_ERR_R3;
                else n_status = STATUS_ERROR;
            end
            S_ERR_R3: begin
                if (i_char == CH_R) n_state = S_ERR_CR;
                else n_status = STATUS_ERROR;
            end
            S_ERR_CR: begin
                if (i_char == CH_CR) n_state = S_ERR_LF;
                else n_status = STATUS_ERROR;
            end
            S_ERR_LF: begin
                // ERROR response ends here; reports error either way
                if (i_char == CH_LF) n_state = S_WAIT_CR;
                n_status = STATUS_ERROR;
            end
            S_TEXT: begin
                if (i_char >= TEXT_LO && i_char <= TEXT_HI) n_state = S_TEXT;
                else if (i_char == CH_CR) n_state = S_TEXT_LF;
                else n_status = STATUS_ERROR;
            end
            S_TEXT_LF: begin
                if (i_char == CH_LF) n_state = S_LINE_START;
                else n_status = STATUS_ERROR;
            end
            S_LINE_START: begin
                if (i_char == CH_PLUS) n_state = S_TEXT;
                else if (i_char == CH_CR) n_state = S_BLANK_LF;
                else n_status = STATUS_ERROR;
            end
            S_BLANK_LF: begin
                if (i_char == CH_LF) n_state = S_FINAL;
                else n_status = STATUS_ERROR;
            end
            S_FINAL: begin
                if (i_char == CH_O) n_state = S_OK_K;
                else if (i_char == CH_E) n_state = S_ERR_R1;
                else n_status = STATUS_ERROR;
            end
            default: begin
                n_state = S_WAIT_CR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT_CR;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_status = n_status;

    // Completed OK response always returns to the start
    a_ok_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_status == STATUS_OK) |=> (r_state == S_WAIT_CR))
        else $error("OK status did not return parser to start");

    // Grammar violation holds the state, except on the final ERROR line
    a_err_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_status == STATUS_ERROR && r_state != S_ERR_LF) |=> $stable(r_state))
        else $error("parse state moved on a grammar error");

    // No word, no movement
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_state))
        else $error("parse state moved without a word");

endmodule

FILE: hw/rtl/at_response_parser_unit.sv
// Top level of the AT response parser: input register, grammar checker, result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_char [7:0]
//  out     | output    | o_out_valid / i_out_stall  | o_status  [1:0]
//
// One word per cycle sustained while the output is not stalled; each word's status
// is presented on the output once the word has passed through the input register,
// one pass of the grammar state machine and the result register.
// Synchronous active-low reset puts the parser at "waiting for CR" and empties
// both registers.
// A stalled result holds in the result register while the input register
// still takes one more word; o_in_stall rises only when both are full.
module at_response_parser_unit
    import atrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status
);

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_char;

    // result register
    logic       r_out_valid;
    logic [1:0] r_out_status;

    logic       out_free;   // result register can take a new status
    logic       s1_adv;     // buffered word is parsed this cycle
    logic       in_take;    // new word accepted this cycle
    logic [1:0] step_status;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Parse state only advances when the word's status moves to the output
    atrp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_char   (r_s1_char),
        .o_status (step_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_char <= i_in_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= step_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

    // Upstream stalls only when both registers are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room to spare");

    // A buffered word under stall is still there next cycle
    a_s1_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("buffered word lost");

    // Only defined status codes leave the block
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_NOT_READY || o_status == STATUS_OK ||
                         o_status == STATUS_ERROR))
        else $error("illegal status code");

endmodule
